// ===== rtl/core/gbi_pkg.sv =====
// Shared types and constants for the grid bilinear interpolator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package gbi_pkg;

    localparam int KIND_W   = 2;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 5;
    localparam int VAL_W    = 32;
    localparam int QLAT_W   = 24;
    localparam int QMLT_W   = 21;
    localparam int LATCNT_W = 7;
    localparam int MLTCNT_W = 6;
    localparam int CFG_W    = 7;
    localparam int CFGIDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_LAT_WR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MLT_WR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GRID_WR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd3;

    localparam logic [CFGIDX_W-1:0] REG_LAT_COUNT = 1'd0;
    localparam logic [CFGIDX_W-1:0] REG_MLT_COUNT = 1'd1;

    localparam logic AX_LAT = 1'b0;
    localparam logic AX_MLT = 1'b1;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_IDLE    = 4'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 4'd1;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd2;
    localparam logic [OP_W-1:0] OP_RD_FIRST = 4'd3;
    localparam logic [OP_W-1:0] OP_RD_LAST = 4'd4;
    localparam logic [OP_W-1:0] OP_CHECK   = 4'd5;
    localparam logic [OP_W-1:0] OP_RD_MID  = 4'd6;
    localparam logic [OP_W-1:0] OP_RD_MID1 = 4'd7;
    localparam logic [OP_W-1:0] OP_EVAL    = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV     = 4'd9;
    localparam logic [OP_W-1:0] OP_DIVEND  = 4'd10;
    localparam logic [OP_W-1:0] OP_GRID    = 4'd11;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd12;
    localparam logic [OP_W-1:0] OP_ADD     = 4'd13;
    localparam logic [OP_W-1:0] OP_OUT     = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            axis;
        logic [2:0]      step;
    } t_cmd;

    typedef struct packed {
        logic outside;
        logic stop;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/core/gbi_ctrl.sv =====
// Sequencer for the interpolator: handshakes, search loop, divide count, blend steps.
// Depends on gbi_pkg; drives gbi_datapath through t_cmd and reads t_status.
`default_nettype none
module gbi_ctrl import gbi_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [KIND_W-1:0] i_kind,
    output logic                   o_valid,
    input  wire logic              i_ready,
    input  wire t_status           i_status,
    output t_cmd                   o_cmd
);

    localparam int CW = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FIRST  = 4'd1;
    localparam logic [3:0] ST_LAST   = 4'd2;
    localparam logic [3:0] ST_CHECK  = 4'd3;
    localparam logic [3:0] ST_MID    = 4'd4;
    localparam logic [3:0] ST_MID1   = 4'd5;
    localparam logic [3:0] ST_EVAL   = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_DIVEND = 4'd8;
    localparam logic [3:0] ST_GRID   = 4'd9;
    localparam logic [3:0] ST_MUL    = 4'd10;
    localparam logic [3:0] ST_ADD    = 4'd11;
    localparam logic [3:0] ST_OUT    = 4'd12;

    logic [3:0]    r_state, n_state;
    logic          r_axis, n_axis;
    logic [2:0]    r_step, n_step;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_valid, n_valid;
    logic          accept;
    logic          load_out;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;

    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_step   = r_step;
        n_cnt    = r_cnt;
        load_out = 1'b0;
        o_cmd.op   = OP_IDLE;
        o_cmd.axis = r_axis;
        o_cmd.step = r_step;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_QUERY) begin
                        o_cmd.op = OP_LOAD;
                        n_axis   = AX_LAT;
                        n_state  = ST_FIRST;
                    end else begin
                        o_cmd.op = OP_WRITE;
                    end
                end
            end
            ST_FIRST: begin
                o_cmd.op = OP_RD_FIRST;
                n_state  = ST_LAST;
            end
            ST_LAST: begin
                o_cmd.op = OP_RD_LAST;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.op = OP_CHECK;
                if (i_status.outside) begin
                    if (r_axis == AX_LAT) begin
                        n_axis  = AX_MLT;
                        n_state = ST_FIRST;
                    end else begin
                        n_step  = 3'd0;
                        n_state = ST_GRID;
                    end
                end else begin
                    n_state = ST_MID;
                end
            end
            ST_MID: begin
                o_cmd.op = OP_RD_MID;
                n_state  = ST_MID1;
            end
            ST_MID1: begin
                o_cmd.op = OP_RD_MID1;
                n_state  = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.op = OP_EVAL;
                if (i_status.stop) begin
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_MID;
                end
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CW'(FRACTION_BITS - 1)) begin
                    n_state = ST_DIVEND;
                end
            end
            ST_DIVEND: begin
                o_cmd.op = OP_DIVEND;
                if (r_axis == AX_LAT) begin
                    n_axis  = AX_MLT;
                    n_state = ST_FIRST;
                end else begin
                    n_step  = 3'd0;
                    n_state = ST_GRID;
                end
            end
            ST_GRID: begin
                o_cmd.op = OP_GRID;
                n_step   = r_step + 3'd1;
                if (r_step == 3'd4) begin
                    n_step  = 3'd0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.op = OP_ADD;
                if (r_step == 3'd2) begin
                    n_state = ST_OUT;
                end else begin
                    n_step  = r_step + 3'd1;
                    n_state = ST_MUL;
                end
            end
            ST_OUT: begin
                if (!r_valid || i_ready) begin
                    o_cmd.op = OP_OUT;
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_valid = (r_valid && !i_ready) || load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= AX_LAT;
            r_step  <= 3'd0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/gbi_datapath.sv =====
// Datapath: axis and grid memories, bisection registers, serial divider, shared multiplier.
// Depends on gbi_pkg; sequenced by gbi_ctrl through t_cmd.
`default_nettype none
module gbi_datapath import gbi_pkg::*; #(
    parameter int MAX_LAT_POINTS = 64,
    parameter int MAX_MLT_POINTS = 32,
    parameter int FRACTION_BITS  = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cmd                       i_cmd,
    output t_status                         o_status,
    input  wire logic [KIND_W-1:0]          i_kind,
    input  wire logic [ROW_W-1:0]           i_row_index,
    input  wire logic [COL_W-1:0]           i_col_index,
    input  wire logic signed [VAL_W-1:0]    i_write_value,
    input  wire logic signed [QLAT_W-1:0]   i_query_lat,
    input  wire logic [QMLT_W-1:0]          i_query_mlt,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFGIDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]           i_cfg_data,
    output logic signed [VAL_W-1:0]         o_value,
    output logic                            o_lat_outside,
    output logic                            o_mlt_outside
);

    localparam int LAW = (MAX_LAT_POINTS > 1) ? $clog2(MAX_LAT_POINTS) : 1;
    localparam int MAW = (MAX_MLT_POINTS > 1) ? $clog2(MAX_MLT_POINTS) : 1;
    localparam int IW  = (LAW > MAW) ? LAW : MAW;
    localparam int GAW = $clog2(MAX_LAT_POINTS * MAX_MLT_POINTS);
    localparam int FB  = FRACTION_BITS;
    localparam int FW  = FB + 1;
    localparam int AXW = 34;
    localparam int PW  = 33 + FW + 1;

    localparam logic [1:0] SPEC_NONE = 2'd0;
    localparam logic [1:0] SPEC_ZERO = 2'd1;
    localparam logic [1:0] SPEC_FULL = 2'd2;

    logic [LATCNT_W-1:0] r_lat_count;
    logic [MLTCNT_W-1:0] r_mlt_count;

    logic signed [VAL_W-1:0] lat_mem  [MAX_LAT_POINTS];
    logic signed [VAL_W-1:0] mlt_mem  [MAX_MLT_POINTS];
    logic signed [VAL_W-1:0] grid_mem [MAX_LAT_POINTS * MAX_MLT_POINTS];
    logic signed [VAL_W-1:0] r_lat_rd, r_mlt_rd, r_grid_rd;

    logic [QLAT_W-1:0]       r_q_lat;
    logic [QMLT_W-1:0]       r_q_mlt;
    logic signed [VAL_W-1:0] r_a_first, r_am;
    logic [IW-1:0]           r_lo, r_hi, r_mid;
    logic [AXW-1:0]          r_rem, r_den;
    logic [FB-1:0]           r_quo;
    logic [1:0]              r_spec;
    logic [LAW-1:0]          r_seg_lat;
    logic [MAW-1:0]          r_seg_mlt;
    logic [FW-1:0]           r_frac_lat, r_frac_mlt;
    logic                    r_lo_flag, r_mo_flag;
    logic signed [VAL_W-1:0] r_v00, r_v01, r_v10, r_v11;
    logic signed [PW-1:0]    r_prod;
    logic signed [VAL_W-1:0] r_r0, r_r1, r_res;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_lo, r_out_mo;

    logic                    ax;
    logic signed [VAL_W-1:0] rd_val;
    logic signed [AXW-1:0]   q_cur, am_x, rd_x, first_x, num, den;
    logic [IW-1:0]           lat_last, mlt_last, n_last, span, ax_idx;
    logic [IW-1:0]           lo_nx, hi_nx, mid_nx;
    logic                    stop, outside;
    logic [AXW:0]            rem2, rem_sub;
    logic [LAW-1:0]          g_row;
    logic [MAW-1:0]          g_col;
    logic [GAW-1:0]          g_raddr, g_waddr;
    logic signed [32:0]      mul_diff;
    logic [FW-1:0]           mul_frac;
    logic signed [PW-1:0]    mul_a, mul_b;
    logic signed [VAL_W-1:0] add_base, add_sum;
    logic [FW-1:0]           frac_end;
    logic                    wr_lat, wr_mlt, wr_grid;
    int                      lat_n, mlt_n;

    assign ax = i_cmd.axis;

    always_comb begin
        lat_n = int'(r_lat_count);
        mlt_n = int'(r_mlt_count);
        if (lat_n < 2) lat_n = 2;
        if (lat_n > MAX_LAT_POINTS) lat_n = MAX_LAT_POINTS;
        if (mlt_n < 2) mlt_n = 2;
        if (mlt_n > MAX_MLT_POINTS) mlt_n = MAX_MLT_POINTS;
        lat_last = IW'(lat_n - 1);
        mlt_last = IW'(mlt_n - 1);
    end

    assign n_last  = (ax == AX_MLT) ? mlt_last : lat_last;
    assign rd_val  = (ax == AX_MLT) ? r_mlt_rd : r_lat_rd;
    assign q_cur   = (ax == AX_MLT) ? $signed(AXW'(r_q_mlt)) : $signed(AXW'(r_q_lat));
    assign am_x    = AXW'(r_am);
    assign rd_x    = AXW'(rd_val);
    assign first_x = AXW'(r_a_first);
    assign num     = q_cur - am_x;
    assign den     = rd_x - am_x;
    assign span    = r_hi - r_lo;
    assign stop    = (span <= IW'(1)) || (am_x == q_cur) || ((am_x <= q_cur) && (rd_x > q_cur));
    assign outside = (q_cur < first_x) || (q_cur > rd_x);

    assign o_status.outside = outside;
    assign o_status.stop    = stop;

    always_comb begin
        lo_nx = r_lo;
        hi_nx = r_hi;
        if (am_x < q_cur) begin
            lo_nx = r_mid;
        end else begin
            hi_nx = r_mid;
        end
        mid_nx = IW'(({1'b0, lo_nx} + {1'b0, hi_nx}) >> 1);
    end

    always_comb begin
        case (i_cmd.op)
            OP_RD_LAST: ax_idx = n_last;
            OP_RD_MID:  ax_idx = r_mid;
            OP_RD_MID1: ax_idx = r_mid + IW'(1);
            default:    ax_idx = '0;
        endcase
    end

    assign g_row   = r_seg_lat + LAW'(i_cmd.step[1]);
    assign g_col   = r_seg_mlt + MAW'(i_cmd.step[0]);
    assign g_raddr = GAW'(g_row) * GAW'(MAX_MLT_POINTS) + GAW'(g_col);
    assign g_waddr = GAW'(i_row_index) * GAW'(MAX_MLT_POINTS) + GAW'(i_col_index);

    assign wr_lat  = (i_cmd.op == OP_WRITE) && (i_kind == KIND_LAT_WR)
                     && (32'(i_row_index) < MAX_LAT_POINTS);
    assign wr_mlt  = (i_cmd.op == OP_WRITE) && (i_kind == KIND_MLT_WR)
                     && (32'(i_col_index) < MAX_MLT_POINTS);
    assign wr_grid = (i_cmd.op == OP_WRITE) && (i_kind == KIND_GRID_WR)
                     && (32'(i_row_index) < MAX_LAT_POINTS)
                     && (32'(i_col_index) < MAX_MLT_POINTS);

    always_ff @(posedge i_clk) begin
        if (wr_lat) begin
            lat_mem[LAW'(i_row_index)] <= i_write_value;
        end
        r_lat_rd <= lat_mem[LAW'(ax_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (wr_mlt) begin
            mlt_mem[MAW'(i_col_index)] <= i_write_value;
        end
        r_mlt_rd <= mlt_mem[MAW'(ax_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (wr_grid) begin
            grid_mem[g_waddr] <= i_write_value;
        end
        r_grid_rd <= grid_mem[g_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_count <= LATCNT_W'(64);
            r_mlt_count <= MLTCNT_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LAT_COUNT: r_lat_count <= i_cfg_data[LATCNT_W-1:0];
                REG_MLT_COUNT: r_mlt_count <= i_cfg_data[MLTCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // restoring divide, one quotient bit per cycle; remainder stays below den when num < den
    assign rem2    = {r_rem, 1'b0};
    assign rem_sub = rem2 - {1'b0, r_den};
    assign frac_end = (r_spec == SPEC_ZERO) ? '0 :
                      (r_spec == SPEC_FULL) ? {1'b1, {FB{1'b0}}} : {1'b0, r_quo};

    always_comb begin
        case (i_cmd.step)
            3'd0: begin
                mul_diff = 33'(r_v01) - 33'(r_v00);
                mul_frac = r_frac_mlt;
                add_base = r_v00;
            end
            3'd1: begin
                mul_diff = 33'(r_v11) - 33'(r_v10);
                mul_frac = r_frac_mlt;
                add_base = r_v10;
            end
            default: begin
                mul_diff = 33'(r_r1) - 33'(r_r0);
                mul_frac = r_frac_lat;
                add_base = r_r0;
            end
        endcase
        mul_a   = PW'(mul_diff);
        mul_b   = $signed(PW'(mul_frac));
        add_sum = add_base + VAL_W'(r_prod >>> FB);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_q_lat <= i_query_lat[QLAT_W-1] ? QLAT_W'(-i_query_lat)
                                                 : QLAT_W'(i_query_lat);
                r_q_mlt <= i_query_mlt;
            end
            OP_RD_LAST: r_a_first <= rd_val;
            OP_CHECK: begin
                r_lo  <= '0;
                r_hi  <= n_last;
                r_mid <= n_last >> 1;
                if (outside) begin
                    if (ax == AX_MLT) begin
                        r_seg_mlt  <= '0;
                        r_frac_mlt <= '0;
                        r_mo_flag  <= 1'b1;
                    end else begin
                        r_seg_lat  <= '0;
                        r_frac_lat <= '0;
                        r_lo_flag  <= 1'b1;
                    end
                end
            end
            OP_RD_MID1: r_am <= rd_val;
            OP_EVAL: begin
                if (stop) begin
                    r_rem <= num;
                    r_den <= den;
                    r_quo <= '0;
                    if ((num <= 0) || (den <= 0)) begin
                        r_spec <= SPEC_ZERO;
                    end else if (num >= den) begin
                        r_spec <= SPEC_FULL;
                    end else begin
                        r_spec <= SPEC_NONE;
                    end
                end else begin
                    r_lo  <= lo_nx;
                    r_hi  <= hi_nx;
                    r_mid <= mid_nx;
                end
            end
            OP_DIV: begin
                if (!rem_sub[AXW]) begin
                    r_rem <= rem_sub[AXW-1:0];
                    r_quo <= {r_quo[FB-2:0], 1'b1};
                end else begin
                    r_rem <= rem2[AXW-1:0];
                    r_quo <= {r_quo[FB-2:0], 1'b0};
                end
            end
            OP_DIVEND: begin
                if (ax == AX_MLT) begin
                    r_seg_mlt  <= MAW'(r_mid);
                    r_frac_mlt <= frac_end;
                    r_mo_flag  <= 1'b0;
                end else begin
                    r_seg_lat  <= LAW'(r_mid);
                    r_frac_lat <= frac_end;
                    r_lo_flag  <= 1'b0;
                end
            end
            OP_GRID: begin
                case (i_cmd.step)
                    3'd1:    r_v00 <= r_grid_rd;
                    3'd2:    r_v01 <= r_grid_rd;
                    3'd3:    r_v10 <= r_grid_rd;
                    3'd4:    r_v11 <= r_grid_rd;
                    default: ;
                endcase
            end
            OP_MUL: r_prod <= mul_a * mul_b;
            OP_ADD: begin
                case (i_cmd.step)
                    3'd0:    r_r0  <= add_sum;
                    3'd1:    r_r1  <= add_sum;
                    default: r_res <= add_sum;
                endcase
            end
            OP_OUT: begin
                r_out_value <= r_res;
                r_out_lo    <= r_lo_flag;
                r_out_mo    <= r_mo_flag;
            end
            default: ;
        endcase
    end

    assign o_value       = r_out_value;
    assign o_lat_outside = r_out_lo;
    assign o_mlt_outside = r_out_mo;

endmodule
`default_nettype wire

// ===== rtl/core/grid_bilinear_interpolator.sv =====
// Grid bilinear interpolator. A write word (kinds 0..2) loads the latitude axis, the
// local-time axis or one grid entry. A query word bisects each axis with two registered
// memory reads per probe, then divides one quotient bit per cycle, then reads four grid
// corners and blends them with one shared multiplier; an axis outside its range skips
// its probes and divide. One word is worked on at a time; the output register lets the
// next word in while a result waits.
// Depends on gbi_pkg, gbi_ctrl and gbi_datapath.
`default_nettype none
module grid_bilinear_interpolator import gbi_pkg::*; #(
    parameter int MAX_LAT_POINTS = 64,
    parameter int MAX_MLT_POINTS = 32,
    parameter int FRACTION_BITS  = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [KIND_W-1:0]        i_kind,
    input  wire logic [ROW_W-1:0]         i_row_index,
    input  wire logic [COL_W-1:0]         i_col_index,
    input  wire logic signed [VAL_W-1:0]  i_write_value,
    input  wire logic signed [QLAT_W-1:0] i_query_lat,
    input  wire logic [QMLT_W-1:0]        i_query_mlt,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [VAL_W-1:0]       o_value,
    output logic                          o_lat_outside,
    output logic                          o_mlt_outside,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFGIDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_W-1:0]         i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    gbi_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_kind  (i_kind),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_status(status),
        .o_cmd   (cmd)
    );

    gbi_datapath #(
        .MAX_LAT_POINTS(MAX_LAT_POINTS),
        .MAX_MLT_POINTS(MAX_MLT_POINTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_kind),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_write_value(i_write_value),
        .i_query_lat  (i_query_lat),
        .i_query_mlt  (i_query_mlt),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_value      (o_value),
        .o_lat_outside(o_lat_outside),
        .o_mlt_outside(o_mlt_outside)
    );

`ifndef SYNTHESIS
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_kind == KIND_QUERY)) |=> !o_ready)
        else $error("accepted query did not drop ready");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_kind != KIND_QUERY) && !o_valid) |=> !o_valid)
        else $error("write word produced a result");

    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without a query in progress");
`endif

endmodule
`default_nettype wire
